// ===== rtl/core/soms_pkg.sv =====
// ----------------------------------------------------------------------------
// soms_pkg: shared types and constants of the spiral order matrix scan
// Sizes, register indexes, walk direction codes, control structs and the
// size saturation helpers.
// ----------------------------------------------------------------------------
package soms_pkg;

    // Matrix limits and element width
    localparam int MAX_ROWS    = 8;
    localparam int MAX_COLUMNS = 8;
    localparam int DATA_WIDTH  = 32;

    // Row / column index widths
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    // Widths able to hold a count of rows, columns, elements
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);
    localparam int COLS_W = $clog2(MAX_COLUMNS + 1);
    localparam int CNT_W  = $clog2(MAX_ROWS * MAX_COLUMNS + 1);

    // Element store: address is {row, column}
    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int STORE_DEPTH = 2 ** ADDR_W;

    // Configuration port
    localparam int SIZE_W    = 4;
    localparam int REG_IDX_W = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ROW_COUNT    = 2'd0,
        REG_COLUMN_COUNT = 2'd1
    } t_reg_idx;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

    // Top-level sequencing
    typedef enum logic {
        ST_LOAD = 1'b0,
        ST_WALK = 1'b1
    } t_state;

    // Spiral walk direction
    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_UP    = 2'd3
    } t_dir;

    // Control toward the walker
    typedef struct packed {
        logic              start;
        logic              step;
        logic [ROWS_W-1:0] rows;
        logic [COLS_W-1:0] cols;
    } t_walk_ctl;

    // Status from the walker
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_walk_stat;

    // Register value to effective row count: zero reads as 1, large saturates
    function automatic logic [ROWS_W-1:0] eff_rows(input logic [SIZE_W-1:0] v);
        logic [ROWS_W-1:0] res;
        if (v == '0) begin
            res = ROWS_W'(1);
        end else if (v > SIZE_W'(MAX_ROWS)) begin
            res = ROWS_W'(MAX_ROWS);
        end else begin
            res = ROWS_W'(v);
        end
        return res;
    endfunction

    function automatic logic [COLS_W-1:0] eff_cols(input logic [SIZE_W-1:0] v);
        logic [COLS_W-1:0] res;
        if (v == '0) begin
            res = COLS_W'(1);
        end else if (v > SIZE_W'(MAX_COLUMNS)) begin
            res = COLS_W'(MAX_COLUMNS);
        end else begin
            res = COLS_W'(v);
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/soms_if.sv =====
// ----------------------------------------------------------------------------
// soms_if: channel interfaces of the spiral order matrix scan
// Element input, spiral result output and configuration write channels.
// ----------------------------------------------------------------------------

// Matrix element channel
interface soms_in_if import soms_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

// Spiral result channel
interface soms_out_if import soms_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] out_value;
    logic        [ROW_W-1:0]      out_row;
    logic        [COL_W-1:0]      out_column;
    logic                         out_last;

    modport source (output valid, output out_value, output out_row,
                    output out_column, output out_last, input ready);
    modport sink   (input valid, input out_value, input out_row,
                    input out_column, input out_last, output ready);
endinterface

// Configuration write channel
interface soms_cfg_if import soms_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] reg_index;
    logic [SIZE_W-1:0]    reg_data;

    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

// ===== rtl/core/soms_ram.sv =====
// ----------------------------------------------------------------------------
// soms_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held while idle.
// ----------------------------------------------------------------------------
module soms_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 64,
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/soms_walker.sv =====
// ----------------------------------------------------------------------------
// soms_walker: spiral address generator
// Keeps the ring bounds and the cursor; one spiral position per step.
// ----------------------------------------------------------------------------
module soms_walker import soms_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_walk_ctl  i_ctl,
    output t_walk_stat o_stat
);

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_top, n_top, r_bottom, n_bottom;
    logic [COL_W-1:0] r_left, n_left, r_right, n_right;
    t_dir             r_dir, n_dir;
    logic [CNT_W-1:0] r_remain, n_remain;

    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        n_top    = r_top;
        n_bottom = r_bottom;
        n_left   = r_left;
        n_right  = r_right;
        n_dir    = r_dir;
        n_remain = r_remain;

        if (i_ctl.start) begin
            n_row    = '0;
            n_col    = '0;
            n_top    = '0;
            n_left   = '0;
            n_bottom = ROW_W'(i_ctl.rows - 1'b1);
            n_right  = COL_W'(i_ctl.cols - 1'b1);
            n_dir    = DIR_RIGHT;
            n_remain = CNT_W'(i_ctl.rows) * CNT_W'(i_ctl.cols);
        end else if (i_ctl.step) begin
            n_remain = r_remain - 1'b1;
            // past the final element the cursor may wrap; it is never read
            unique case (r_dir)
                DIR_RIGHT: begin
                    if (r_col == r_right) begin
                        n_top = r_top + 1'b1;
                        n_dir = DIR_DOWN;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
                DIR_DOWN: begin
                    if (r_row == r_bottom) begin
                        n_right = r_right - 1'b1;
                        n_dir   = DIR_LEFT;
                        n_col   = r_col - 1'b1;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
                DIR_LEFT: begin
                    if (r_col == r_left) begin
                        n_bottom = r_bottom - 1'b1;
                        n_dir    = DIR_UP;
                        n_row    = r_row - 1'b1;
                    end else begin
                        n_col = r_col - 1'b1;
                    end
                end
                DIR_UP: begin
                    if (r_row == r_top) begin
                        n_left = r_left + 1'b1;
                        n_dir  = DIR_RIGHT;
                        n_col  = r_col + 1'b1;
                    end else begin
                        n_row = r_row - 1'b1;
                    end
                end
                default: begin
                    n_dir = DIR_RIGHT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_top    <= '0;
            r_bottom <= '0;
            r_left   <= '0;
            r_right  <= '0;
            r_dir    <= DIR_RIGHT;
            r_remain <= '0;
        end else begin
            r_row    <= n_row;
            r_col    <= n_col;
            r_top    <= n_top;
            r_bottom <= n_bottom;
            r_left   <= n_left;
            r_right  <= n_right;
            r_dir    <= n_dir;
            r_remain <= n_remain;
        end
    end

    assign o_stat.row  = r_row;
    assign o_stat.col  = r_col;
    assign o_stat.last = (r_remain == CNT_W'(1));

endmodule

// ===== rtl/core/spiral_order_matrix_scan.sv =====
// ----------------------------------------------------------------------------
// spiral_order_matrix_scan: spiral order matrix scan, top level
// Loads a matrix row-major into the element store, then reads it back in
// clockwise spiral order with row, column and end-of-spiral flag.
// ----------------------------------------------------------------------------
//
//  Channel    Dir  Payload                                     Handshake
//  ---------  ---  ------------------------------------------  -----------
//  i_cfg      in   reg_index, reg_data (row / column count)    valid/ready
//  i_elem     in   element_value                               valid/ready
//  o_result   out  out_value, out_row, out_column, out_last    valid/ready
//
//  Loading writes the store once per element transaction.
//  After the last element the spiral is read out at one result per cycle
//  while o_result is ready, bound by the single read port of the store; the
//  first read follows once the walker and the state register have started.
//  i_elem.ready is low while the spiral is being read; a stalled o_result
//  holds the read data in the store's output register and pauses the walk.
//  Reset sets both size registers to 8 and empties the load position;
//  the store contents are not cleared. i_cfg is always ready.
// ----------------------------------------------------------------------------
module spiral_order_matrix_scan import soms_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    soms_cfg_if.sink    i_cfg,
    soms_in_if.sink     i_elem,
    soms_out_if.source  o_result
);

    // Size registers and their effective values
    logic [SIZE_W-1:0] r_row_count;
    logic [SIZE_W-1:0] r_col_count;
    logic [ROWS_W-1:0] eff_r;
    logic [COLS_W-1:0] eff_c;

    // Load position, kept as row/column instead of a flat count
    logic [ROW_W-1:0]  r_ld_row, n_ld_row;
    logic [COL_W-1:0]  r_ld_col, n_ld_col;

    t_state            r_state, n_state;

    logic              cfg_wr;
    logic              cfg_size_wr;
    logic              elem_acc;
    logic              ld_last_col;
    logic              ld_last;
    logic              in_ready;
    logic              walking;
    logic              issue;

    // Output stage: value sits in the store's read register
    logic              r_out_valid;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;
    logic              r_out_last;
    logic [DATA_WIDTH-1:0] rd_data;

    t_walk_ctl         walk_ctl;
    t_walk_stat        walk_stat;

    assign eff_r = eff_rows(r_row_count);
    assign eff_c = eff_cols(r_col_count);

    // ---- configuration ----
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    always_comb begin
        cfg_size_wr = 1'b0;
        unique case (i_cfg.reg_index)
            REG_ROW_COUNT:    cfg_size_wr = cfg_wr;
            REG_COLUMN_COUNT: cfg_size_wr = cfg_wr;
            default:          cfg_size_wr = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= SIZE_RESET;
            r_col_count <= SIZE_RESET;
        end else if (cfg_wr) begin
            unique case (i_cfg.reg_index)
                REG_ROW_COUNT:    r_row_count <= i_cfg.reg_data;
                REG_COLUMN_COUNT: r_col_count <= i_cfg.reg_data;
                default: begin
                end
            endcase
        end
    end

    // ---- load side ----
    assign elem_acc    = i_elem.valid && in_ready;
    assign ld_last_col = (r_ld_col == COL_W'(eff_c - 1'b1));
    assign ld_last     = ld_last_col && (r_ld_row == ROW_W'(eff_r - 1'b1));

    always_comb begin
        n_ld_row = r_ld_row;
        n_ld_col = r_ld_col;
        if (cfg_size_wr) begin
            // a size change drops any partly loaded matrix
            n_ld_row = '0;
            n_ld_col = '0;
        end else if (elem_acc) begin
            if (ld_last) begin
                n_ld_row = '0;
                n_ld_col = '0;
            end else if (ld_last_col) begin
                n_ld_row = r_ld_row + 1'b1;
                n_ld_col = '0;
            end else begin
                n_ld_col = r_ld_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_row <= '0;
            r_ld_col <= '0;
        end else begin
            r_ld_row <= n_ld_row;
            r_ld_col <= n_ld_col;
        end
    end

    // ---- sequencing: next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (elem_acc && ld_last) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (issue && walk_stat.last) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // ---- sequencing: outputs ----
    always_comb begin
        in_ready = 1'b0;
        walking  = 1'b0;
        unique case (r_state)
            ST_LOAD: in_ready = 1'b1;
            ST_WALK: walking  = 1'b1;
            default: begin
                in_ready = 1'b0;
                walking  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_elem.ready = in_ready;

    // read the next spiral position whenever the output slot is free or drains
    assign issue = walking && (!r_out_valid || o_result.ready);

    assign walk_ctl.start = elem_acc && ld_last;
    assign walk_ctl.step  = issue;
    assign walk_ctl.rows  = eff_r;
    assign walk_ctl.cols  = eff_c;

    soms_walker u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (walk_ctl),
        .o_stat  (walk_stat)
    );

    soms_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (elem_acc),
        .i_wr_addr ({r_ld_row, r_ld_col}),
        .i_wr_data (i_elem.element_value),
        .i_rd_en   (issue),
        .i_rd_addr ({walk_stat.row, walk_stat.col}),
        .o_rd_data (rd_data)
    );

    // ---- result stage ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (issue) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_out_row  <= walk_stat.row;
            r_out_col  <= walk_stat.col;
            r_out_last <= walk_stat.last;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.out_value  = $signed(rd_data);
    assign o_result.out_row    = r_out_row;
    assign o_result.out_column = r_out_col;
    assign o_result.out_last   = r_out_last;

endmodule

// ===== tb/spiral_order_matrix_scan_tb.sv =====
// ----------------------------------------------------------------------------
// spiral_order_matrix_scan_tb: self-checking bench of the spiral matrix scan
// Streams matrices of random and corner-case words through the element
// channel and predicts the spiral read-out of each one. Every result
// transaction is checked field by field against the oldest expected cell.
// The element sender idles and the result receiver stalls at random.
// ----------------------------------------------------------------------------
module spiral_order_matrix_scan_tb;
    import soms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Run control
    localparam int LIMIT_CYCLES  = 200000;  // watchdog, far beyond the slowest run
    localparam int SETTLE_CYCLES = 4;       // idle pause before a register write
    localparam int END_CYCLES    = 40;      // trailing window after the last result
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int RANDOM_ITEMS  = 190;

    // Register indexes that do not map to a register
    localparam logic [REG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN   = 2'd0,   // always ready
        RX_COIN   = 2'd1,   // ready half the time
        RX_SPARSE = 2'd2,   // ready one cycle in four on average
        RX_COMB   = 2'd3    // regular on/off pattern
    } t_rx_mode;

    // One expected spiral cell
    typedef struct {
        logic signed [DATA_WIDTH-1:0] value;
        logic        [ROW_W-1:0]      row;
        logic        [COL_W-1:0]      column;
        logic                         last;
    } t_spiral_cell;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    soms_cfg_if cfg_ch ();
    soms_in_if  elem_ch ();
    soms_out_if result_ch ();

    spiral_order_matrix_scan dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_elem   (elem_ch),
        .o_result (result_ch)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Scoreboard state: our own copy of the matrix store, the load position
    // and the size registers, plus the queue of cells still to come out.
    // ------------------------------------------------------------------------
    logic signed [DATA_WIDTH-1:0] matrix_mem [MAX_ROWS*MAX_COLUMNS];
    int                           loaded_cnt;
    logic [SIZE_W-1:0]            row_reg;
    logic [SIZE_W-1:0]            col_reg;
    t_spiral_cell                 spiral_q [$];

    // Pending element transactions for the driver
    logic signed [DATA_WIDTH-1:0] element_q [$];
    int                           n_queued   = 0;
    int                           n_accepted = 0;

    int mismatches = 0;

    // Long hold-off requests: the stimulus bumps hold_req, the receiver
    // serves each bump once
    int hold_req  = 0;
    int hold_done = 0;

    // Register value to size in use: zero means one, anything above the
    // maximum saturates
    function automatic int size_in_use(input logic [SIZE_W-1:0] v, input int max);
        int sz;
        sz = int'(v);
        if (sz == 0) begin
            sz = 1;
        end else if (sz > max) begin
            sz = max;
        end
        return sz;
    endfunction

    function automatic void add_cell(input int r, input int c, inout int n, input int total);
        t_spiral_cell entry;
        n++;
        entry.value  = matrix_mem[r*MAX_COLUMNS + c];
        entry.row    = ROW_W'(r);
        entry.column = COL_W'(c);
        entry.last   = (n == total);
        spiral_q.insert(spiral_q.size(), entry);
    endfunction

    // Clockwise walk, ring by ring; the side checks keep single rows and
    // columns from repeating cells
    function automatic void queue_spiral(input int rows, input int cols);
        int top, bottom, left, right, k, n, total;
        top    = 0;
        bottom = rows - 1;
        left   = 0;
        right  = cols - 1;
        n      = 0;
        total  = rows * cols;
        while (top <= bottom && left <= right) begin
            for (k = left; k <= right; k++) add_cell(top, k, n, total);
            top++;
            for (k = top; k <= bottom; k++) add_cell(k, right, n, total);
            right--;
            if (top <= bottom) begin
                for (k = right; k >= left; k--) add_cell(bottom, k, n, total);
                bottom--;
            end
            if (left <= right) begin
                for (k = bottom; k >= top; k--) add_cell(k, left, n, total);
                left++;
            end
        end
    endfunction

    // Store one element row-major; the last one of the matrix releases
    // the whole spiral
    function automatic void load_element(input logic signed [DATA_WIDTH-1:0] v);
        int rows, cols, total;
        rows  = size_in_use(row_reg, MAX_ROWS);
        cols  = size_in_use(col_reg, MAX_COLUMNS);
        total = rows * cols;
        if (loaded_cnt >= total) loaded_cnt = 0;
        matrix_mem[(loaded_cnt / cols) * MAX_COLUMNS + (loaded_cnt % cols)] = v;
        loaded_cnt++;
        if (loaded_cnt == total) begin
            loaded_cnt = 0;
            queue_spiral(rows, cols);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Element driver: bursts of random length with random gaps. A
    // transaction completes at an edge with valid and ready both high; the
    // accepted word goes to the scoreboard right there.
    // ------------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            elem_ch.valid         <= 1'b0;
            elem_ch.element_value <= '0;
            burst_left = $urandom_range(1, 24);
            gap_left   = 0;
        end else begin
            if (elem_ch.valid && elem_ch.ready) begin
                load_element(elem_ch.element_value);
                n_accepted++;
            end
            // Only move on once the current word is gone
            if (!elem_ch.valid || elem_ch.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    elem_ch.valid <= 1'b0;
                end else if (element_q.size() != 0) begin
                    elem_ch.valid         <= 1'b1;
                    elem_ch.element_value <= element_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        // a third of the bursts run straight into the next
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    elem_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: stall pattern that changes after a random span,
    // plus the long hold-off that lets the block fill up and push back.
    // ------------------------------------------------------------------------
    t_rx_mode    rx_mode;
    int          rx_mode_left;
    int          rx_hold_left;
    logic [3:0]  rx_tick;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            rx_mode      = RX_OPEN;
            rx_mode_left = 0;
            rx_hold_left = 0;
            rx_tick      = '0;
            hold_done    = 0;
        end else begin
            rx_tick++;
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(8, 80);
            end else begin
                rx_mode_left--;
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                result_ch.ready <= 1'b0;
            end else if (hold_done != hold_req) begin
                hold_done    = hold_req;
                rx_hold_left = HOLD_CYCLES;
                result_ch.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:   result_ch.ready <= 1'b1;
                    RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   result_ch.ready <= rx_tick[1];
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: every accepted result transaction must match the
    // oldest expected cell; one with nothing expected is a failure too.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_spiral_cell want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (spiral_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected result value=%h row=%0d col=%0d last=%0b",
                             $realtime, result_ch.out_value, result_ch.out_row,
                             result_ch.out_column, result_ch.out_last);
                end
            end else begin
                want = spiral_q.pop_front();
                if (result_ch.out_value  !== want.value  ||
                    result_ch.out_row    !== want.row    ||
                    result_ch.out_column !== want.column ||
                    result_ch.out_last   !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: mismatch exp value=%h row=%0d col=%0d last=%0b",
                                 $realtime, want.value, want.row, want.column, want.last);
                        $display("%0t:          got value=%h row=%0d col=%0d last=%0b",
                                 $realtime, result_ch.out_value, result_ch.out_row,
                                 result_ch.out_column, result_ch.out_last);
                    end
                end
            end
        end
    end

    // Watchdog
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("spiral_order_matrix_scan_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_element(input logic signed [DATA_WIDTH-1:0] v);
        element_q.insert(element_q.size(), v);
        n_queued++;
    endtask

    // Every queued element accepted and every expected cell seen
    task automatic wait_drained();
        do @(posedge i_clk);
        while (n_accepted != n_queued || spiral_q.size() != 0);
    endtask

    // Idle point for register writes: drained, then a short settle so the
    // last store write of a partial matrix is surely done
    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write transaction; a write to either size register
    // throws away a partly loaded matrix
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.reg_data  <= val;
        do @(posedge i_clk);
        while (!cfg_ch.ready);
        if (idx == REG_ROW_COUNT) begin
            row_reg    = val;
            loaded_cnt = 0;
        end else if (idx == REG_COLUMN_COUNT) begin
            col_reg    = val;
            loaded_cnt = 0;
        end
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly full-range random words, with the extremes mixed in
    function automatic logic signed [DATA_WIDTH-1:0] pick_word();
        logic signed [DATA_WIDTH-1:0] w;
        case ($urandom_range(0, 9))
            0:       w = 32'sh8000_0000;
            1:       w = 32'sh7fff_ffff;
            2:       w = '0;
            3:       w = '1;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [SIZE_W-1:0] rv, cv;
        int rows, cols, total, nmat, phase, random_items, m, k;

        // Known levels on every input from time zero
        cfg_ch.valid          = 1'b0;
        cfg_ch.reg_index      = '0;
        cfg_ch.reg_data       = '0;
        elem_ch.valid         = 1'b0;
        elem_ch.element_value = '0;
        result_ch.ready       = 1'b0;

        // Scoreboard mirrors the reset state
        row_reg    = SIZE_RESET;
        col_reg    = SIZE_RESET;
        loaded_cnt = 0;
        foreach (matrix_mem[i]) matrix_mem[i] = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part ---------------------------------------------------
        // Partial 8x8 matrix at the reset sizes, abandoned by a row write
        push_element(32'sh8000_0000);
        push_element(32'sh7fff_ffff);
        push_element(32'sh0000_0000);
        wait_idle();
        write_reg(REG_ROW_COUNT, 4'd1);

        // Single row of eight (column count still at its reset value)
        push_element(32'shffff_ffff);
        push_element(32'sh0000_0001);
        push_element(32'sh5555_5555);
        push_element(32'shaaaa_aaaa);
        push_element(32'sh8000_0000);
        push_element(32'sh7fff_ffff);
        push_element(32'sh0000_0000);
        push_element(32'shffff_ffff);
        wait_idle();

        // Zero column count reads as one: 1x1
        write_reg(REG_COLUMN_COUNT, 4'd0);
        push_element(32'sh7fff_ffff);
        wait_idle();

        // Row count saturates at the maximum: single column of eight
        write_reg(REG_ROW_COUNT, 4'd15);
        write_reg(REG_COLUMN_COUNT, 4'd1);
        for (k = 0; k < 8; k++) push_element(k[0] ? 32'sh8000_0000 : 32'sh7fff_ffff);
        wait_idle();

        // 2x2, with writes to the spare indexes in the middle of loading;
        // those leave the load position alone
        write_reg(REG_ROW_COUNT, 4'd2);
        write_reg(REG_COLUMN_COUNT, 4'd2);
        push_element(32'sh1234_5678);
        push_element(32'shedcb_a987);
        wait_idle();
        write_reg(REG_SPARE_2, 4'hf);
        write_reg(REG_SPARE_3, 4'h5);
        push_element(32'sh8000_0000);
        push_element(32'sh7fff_ffff);

        // --- random part -----------------------------------------------------
        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS) begin
            wait_idle();

            if (phase == 1) begin
                // back-pressure phase: two matrices queued behind a long hold
                rv = 4'd8;
                cv = 4'd4;
            end else begin
                case ($urandom_range(0, 9))
                    0: begin rv = 4'd8; cv = 4'd8; end
                    1: begin rv = 4'd1; cv = SIZE_W'($urandom_range(1, 8)); end
                    2: begin rv = SIZE_W'($urandom_range(1, 8)); cv = 4'd1; end
                    3: begin
                        // out-of-range row counts, with any column count
                        rv = $urandom_range(0, 1) ? 4'd0 : SIZE_W'($urandom_range(9, 15));
                        cv = SIZE_W'($urandom_range(0, 15));
                    end
                    default: begin
                        rv = SIZE_W'($urandom_range(1, 4));
                        cv = SIZE_W'($urandom_range(1, 4));
                    end
                endcase
            end

            if ($urandom_range(0, 5) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                          SIZE_W'($urandom_range(0, 15)));
            end
            if ($urandom_range(0, 1)) begin
                write_reg(REG_ROW_COUNT, rv);
                write_reg(REG_COLUMN_COUNT, cv);
            end else begin
                write_reg(REG_COLUMN_COUNT, cv);
                write_reg(REG_ROW_COUNT, rv);
            end

            rows  = size_in_use(rv, MAX_ROWS);
            cols  = size_in_use(cv, MAX_COLUMNS);
            total = rows * cols;
            nmat  = (phase == 1) ? 2 : (total > 32) ? 1 : $urandom_range(1, 3);

            if (phase == 1) hold_req++;

            for (m = 0; m < nmat; m++) begin
                // now and then the sender waits for the spiral to drain
                if (m != 0 && $urandom_range(0, 3) == 0) wait_drained();
                for (k = 0; k < total; k++) push_element(pick_word());
                random_items += total;
            end

            // Broken sequence: a partial matrix that the next size register
            // write throws away
            if (total > 1 && $urandom_range(0, 4) == 0) begin
                k = $urandom_range(1, total - 1);
                random_items += k;
                while (k != 0) begin
                    push_element(pick_word());
                    k--;
                end
            end
            phase++;
        end

        // --- end of run ------------------------------------------------------
        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && spiral_q.size() == 0) begin
            $display("spiral_order_matrix_scan_tb OK");
        end else begin
            $display("spiral_order_matrix_scan_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/soms_pkg.sv
rtl/core/soms_if.sv
rtl/core/soms_ram.sv
rtl/core/soms_walker.sv
rtl/core/spiral_order_matrix_scan.sv
tb/spiral_order_matrix_scan_tb.sv
